/* hw/rtl/tes_pkg.sv */
// Package for the text encoding sniffer.
// Encoding codes, mark byte constants and the scan view struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

    // default sample window in bytes
    localparam int SAMPLE_BYTES_DEF = 4096;

    // encoding codes
    localparam logic [1:0] ENC_UNKNOWN = 2'd0;
    localparam logic [1:0] ENC_UTF16LE = 2'd1;
    localparam logic [1:0] ENC_UTF16BE = 2'd2;
    localparam logic [1:0] ENC_UTF8    = 2'd3;

    // mark lengths
    localparam logic [1:0] BOM_NONE  = 2'd0;
    localparam logic [1:0] BOM_UTF16 = 2'd2;
    localparam logic [1:0] BOM_UTF8  = 2'd3;

    // mark and UTF-8 class bytes
    localparam logic [7:0] BYTE_FF = 8'hff;
    localparam logic [7:0] BYTE_FE = 8'hfe;
    localparam logic [7:0] BYTE_EF = 8'hef;
    localparam logic [7:0] BYTE_BB = 8'hbb;
    localparam logic [7:0] BYTE_BF = 8'hbf;
    localparam logic [7:0] LEAD3_MIN = 8'he0;
    localparam logic [7:0] LEAD2_MIN = 8'hc0;
    localparam logic [7:0] CONT_MIN  = 8'h80;

    // scan state after the current word has been folded in
    typedef struct packed {
        logic [2:0][7:0] head;
        logic [1:0]      zeros;
        logic [1:0]      owed;
        logic            broken;
    } tes_scan_t;

endpackage

`default_nettype wire

/* hw/rtl/text_encoding_sniffer.sv */
// Top level of the text encoding sniffer: input register, scan and result.
// Depends on tes_pkg, tes_scan and tes_result.
`timescale 1ns / 1ps
`default_nettype none

// Takes a file one byte per word on the slave side, tlast on the final byte,
// and gives one result word per file: the encoding (unknown, UTF-16 LE,
// UTF-16 BE, UTF-8) and the byte-order-mark length. One byte is accepted
// every cycle while no closing byte waits on the result register. The byte
// passes through an input register, then the scan state and the classifier
// feed the result register combinationally. Only a closing byte waits on
// the result register; other bytes never stall on it.
// Without a mark, only the first SAMPLE_BYTES bytes are examined.
module text_encoding_sniffer #(
    parameter int SAMPLE_BYTES = tes_pkg::SAMPLE_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [1:0] encoding, [3:2] bom_length, [7:4] zero
);

    logic               in_vld_reg, in_vld_next;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               advance;
    tes_pkg::tes_scan_t view;
    logic [1:0]         encoding, bom_length;

    // a held byte moves on unless it closes a file and the result is stuck
    assign advance  = in_vld_reg && (!in_last_reg || !m_tvalid || m_tready);
    assign s_tready = !in_vld_reg || advance;

    assign in_vld_next = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : in_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tes_scan #(
        .SAMPLE_BYTES(SAMPLE_BYTES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .advance   (advance),
        .view      (view)
    );

    tes_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .view       (view),
        .load       (advance && in_last_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .encoding   (encoding),
        .bom_length (bom_length)
    );

    assign m_tdata = {4'd0, bom_length, encoding};

endmodule

`default_nettype wire

/* hw/rtl/tes_scan.sv */
// Per-byte scan state: head bytes, sample counter, zero count, UTF-8 tracker.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tes_scan #(
    parameter int SAMPLE_BYTES = tes_pkg::SAMPLE_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    input  wire logic             advance,
    output tes_pkg::tes_scan_t    view
);

    localparam int CW = $clog2(SAMPLE_BYTES + 1);

    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [2:0][7:0] head_reg;
    logic [1:0]      zeros_reg, owed_reg;
    logic            broken_reg;
    logic            in_sample;

    assign in_sample = cnt_reg < CW'(SAMPLE_BYTES);

    // fold the word into the state
    always_comb
    begin
        view.head   = head_reg;
        view.zeros  = zeros_reg;
        view.owed   = owed_reg;
        view.broken = broken_reg;
        cnt_next    = cnt_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (cnt_reg == CW'(i))
            begin
                view.head[i] = data_byte;
            end
        end
        if (in_sample)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (data_byte == 8'd0 && zeros_reg != 2'd2)
            begin
                view.zeros = zeros_reg + 2'd1;
            end
            priority if (owed_reg != 2'd0)
            begin
                if (data_byte < tes_pkg::CONT_MIN || data_byte >= tes_pkg::LEAD2_MIN)
                begin
                    view.broken = 1'b1;
                end
                view.owed = owed_reg - 2'd1;
            end
            else if (data_byte >= tes_pkg::LEAD3_MIN)
            begin
                view.owed = 2'd2;
            end
            else if (data_byte >= tes_pkg::LEAD2_MIN)
            begin
                view.owed = 2'd1;
            end
            else if (data_byte >= tes_pkg::CONT_MIN)
            begin
                // stray continuation in lead position
                view.broken = 1'b1;
            end
            else
            begin
                // one-byte character, nothing owed
                view.owed = owed_reg;
            end
        end
    end

    // state registers; a closing word restarts for the next file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            head_reg   <= '0;
            zeros_reg  <= '0;
            owed_reg   <= '0;
            broken_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                cnt_reg    <= '0;
                head_reg   <= '0;
                zeros_reg  <= '0;
                owed_reg   <= '0;
                broken_reg <= 1'b0;
            end
            else
            begin
                cnt_reg    <= cnt_next;
                head_reg   <= view.head;
                zeros_reg  <= view.zeros;
                owed_reg   <= view.owed;
                broken_reg <= view.broken;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tes_result.sv */
// Classifier and result register with the master-side handshake.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tes_result (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tes_pkg::tes_scan_t view,
    input  wire logic               load,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              encoding,
    output logic [1:0]              bom_length
);

    logic       vld_reg, vld_next;
    logic [1:0] enc_reg, bom_reg;
    logic [1:0] enc_next, bom_next;

    // mark check first, then zero count, then UTF-8 structure
    always_comb
    begin
        enc_next = tes_pkg::ENC_UNKNOWN;
        bom_next = tes_pkg::BOM_NONE;
        priority if (view.head[0] == tes_pkg::BYTE_FF && view.head[1] == tes_pkg::BYTE_FE)
        begin
            enc_next = tes_pkg::ENC_UTF16LE;
            bom_next = tes_pkg::BOM_UTF16;
        end
        else if (view.head[0] == tes_pkg::BYTE_FE && view.head[1] == tes_pkg::BYTE_FF)
        begin
            enc_next = tes_pkg::ENC_UTF16BE;
            bom_next = tes_pkg::BOM_UTF16;
        end
        else if (view.head[0] == tes_pkg::BYTE_EF && view.head[1] == tes_pkg::BYTE_BB
                 && view.head[2] == tes_pkg::BYTE_BF)
        begin
            enc_next = tes_pkg::ENC_UTF8;
            bom_next = tes_pkg::BOM_UTF8;
        end
        else if (view.zeros == 2'd2)
        begin
            enc_next = tes_pkg::ENC_UTF16LE;
        end
        else if (!view.broken && view.owed == 2'd0)
        begin
            enc_next = tes_pkg::ENC_UTF8;
        end
        else
        begin
            enc_next = tes_pkg::ENC_UNKNOWN;
        end
    end

    assign vld_next = load ? 1'b1 : (out_ready ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            enc_reg <= enc_next;
            bom_reg <= bom_next;
        end
    end

    assign out_valid  = vld_reg;
    assign encoding   = enc_reg;
    assign bom_length = bom_reg;

endmodule

`default_nettype wire

/* hw/rtl/tes_checker.sv */
// Port-level checker for the text encoding sniffer, bound to the top level.
// Depends on tes_pkg and text_encoding_sniffer.
`timescale 1ns / 1ps
`default_nettype none

module tes_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:4] == 4'd0)
        else $error("result padding not zero");

    // a three-byte mark only comes with UTF-8
    a_bom3: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:2] == tes_pkg::BOM_UTF8 |-> m_tdata[1:0] == tes_pkg::ENC_UTF8)
        else $error("three-byte mark without UTF-8");

    // a two-byte mark only comes with UTF-16
    a_bom2: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:2] == tes_pkg::BOM_UTF16 |->
        m_tdata[1:0] == tes_pkg::ENC_UTF16LE || m_tdata[1:0] == tes_pkg::ENC_UTF16BE)
        else $error("two-byte mark without UTF-16");

    // big-endian is only known from its mark
    a_be: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == tes_pkg::ENC_UTF16BE |->
        m_tdata[3:2] == tes_pkg::BOM_UTF16)
        else $error("big-endian result without mark");

endmodule

bind text_encoding_sniffer tes_checker u_tes_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/sv/tes_verdict_checker.sv */
// Checker for the text encoding sniffer: watches both streams, predicts the
// verdict of each file and compares it with the result words.
// Depends on tes_pkg.
`timescale 1ns / 1ps

module tes_verdict_checker #(
    parameter int SAMPLE_LEN = tes_pkg::SAMPLE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output logic [31:0] faults,
    output logic [31:0] pending,
    output logic [31:0] verdicts_seen
);

    typedef struct packed {
        logic [1:0] enc;
        logic [1:0] bom;
    } verdict_t;

    verdict_t    verdict_q [$];

    // scan of the file in progress
    logic [7:0]  lead_win [0:2];
    int unsigned win_count;
    int unsigned nul_count;
    int unsigned tail_due;
    logic        bad_utf8;

    int unsigned fault_cnt;
    int unsigned verdict_cnt;

    task automatic clear_scan();
        lead_win[0] = '0;
        lead_win[1] = '0;
        lead_win[2] = '0;
        win_count   = 0;
        nul_count   = 0;
        tail_due    = 0;
        bad_utf8    = 1'b0;
    endtask

    // fold one accepted byte into the scan, queue a verdict on the closing byte
    task automatic fold_byte(input logic [7:0] b, input logic closing);
        verdict_t v;
        if (win_count < 3)
            lead_win[win_count] = b;
        if (win_count < SAMPLE_LEN)
        begin
            if (b == '0 && nul_count < 2)
                nul_count++;
            if (tail_due != 0)
            begin
                if (b < tes_pkg::CONT_MIN || b >= tes_pkg::LEAD2_MIN)
                    bad_utf8 = 1'b1;
                tail_due--;
            end
            else if (b >= tes_pkg::LEAD3_MIN)
                tail_due = 2;
            else if (b >= tes_pkg::LEAD2_MIN)
                tail_due = 1;
            else if (b >= tes_pkg::CONT_MIN)
                bad_utf8 = 1'b1;  // stray continuation in lead position
            win_count++;
        end
        if (closing)
        begin
            v.enc = tes_pkg::ENC_UNKNOWN;
            v.bom = tes_pkg::BOM_NONE;
            if (lead_win[0] == tes_pkg::BYTE_FF && lead_win[1] == tes_pkg::BYTE_FE)
            begin
                v.enc = tes_pkg::ENC_UTF16LE;
                v.bom = tes_pkg::BOM_UTF16;
            end
            else if (lead_win[0] == tes_pkg::BYTE_FE && lead_win[1] == tes_pkg::BYTE_FF)
            begin
                v.enc = tes_pkg::ENC_UTF16BE;
                v.bom = tes_pkg::BOM_UTF16;
            end
            else if (lead_win[0] == tes_pkg::BYTE_EF && lead_win[1] == tes_pkg::BYTE_BB &&
                     lead_win[2] == tes_pkg::BYTE_BF)
            begin
                v.enc = tes_pkg::ENC_UTF8;
                v.bom = tes_pkg::BOM_UTF8;
            end
            else if (nul_count >= 2)
                v.enc = tes_pkg::ENC_UTF16LE;
            else if (!bad_utf8 && tail_due == 0)
                v.enc = tes_pkg::ENC_UTF8;
            verdict_q.push_back(v);
            clear_scan();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        if (!rst_n)
        begin
            clear_scan();
            verdict_q.delete();
            fault_cnt   = 0;
            verdict_cnt = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                fold_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                verdict_cnt++;
                if (verdict_q.size() == 0)
                begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("%0t: result word %h with no file pending", $realtime,
                                 m_tdata);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tdata[1:0] !== want.enc || m_tdata[3:2] !== want.bom ||
                        m_tdata[7:4] !== 4'h0)
                    begin
                        fault_cnt++;
                        if (fault_cnt <= 10)
                            $display("%0t: expected enc=%0d bom=%0d, got enc=%0d bom=%0d pad=%h",
                                     $realtime, want.enc, want.bom, m_tdata[1:0],
                                     m_tdata[3:2], m_tdata[7:4]);
                    end
                end
            end
        end
        faults        <= fault_cnt;
        pending       <= verdict_q.size();
        verdicts_seen <= verdict_cnt;
    end

endmodule

/* tb/sv/tb_text_encoding_sniffer.sv */
// Testbench top for the text encoding sniffer: clock, reset, byte stimulus
// and result-side flow control; checking is done in tes_verdict_checker.
// Depends on tes_pkg, tes_verdict_checker and the sniffer RTL.
`timescale 1ns / 1ps

module tb_text_encoding_sniffer;

    localparam int SAMPLE_LEN  = tes_pkg::SAMPLE_BYTES_DEF;
    localparam int RAND_BYTES  = 680;
    localparam int HOLD_CYCLES = 120;

    typedef enum logic [2:0] {
        BODY_UTF8,
        BODY_UTF16,
        BODY_NOISE,
        BODY_BROKEN,
        BODY_TRUNC
    } body_kind_t;

    typedef enum logic [2:0] {
        MARK_NONE,
        MARK_LE,
        MARK_BE,
        MARK_UTF8,
        MARK_PARTIAL
    } mark_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    logic [31:0] faults;
    logic [31:0] pending;
    logic [31:0] verdicts_seen;

    // flow-control knobs of the sender and receiver processes
    logic        calm;
    logic        tx_idle_on;
    logic        rx_idle_on;
    logic        hold_req;
    int unsigned held_cycles;

    int unsigned bytes_sent;
    int unsigned files_sent;
    logic [7:0]  file_buf [$];

    text_encoding_sniffer #(
        .SAMPLE_BYTES (SAMPLE_LEN)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tlast  (s_tlast),   // last_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [1:0] encoding, [3:2] bom_length, [7:4] zero
    );

    tes_verdict_checker #(
        .SAMPLE_LEN (SAMPLE_LEN)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .faults        (faults),
        .pending       (pending),
        .verdicts_seen (verdicts_seen)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #400000;
        $display("FAIL text_encoding_sniffer");
        $finish;
    end

    // offer one word and wait for it to be taken, then maybe idle a burst
    task automatic push_byte(input logic [7:0] b, input logic closing);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= closing;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        if (bytes_sent % 32 == 0)
            tx_idle_on = ($urandom_range(0, 2) != 0);
        if (!calm && tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
    endtask

    // stream file_buf out as one file
    task automatic send_file();
        int unsigned i;
        for (i = 0; i < file_buf.size(); i++)
            push_byte(file_buf[i], i == file_buf.size() - 1);
        files_sent++;
    endtask

    // one well-formed UTF-8 character, one to three bytes
    task automatic add_utf8_char();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 5)
        begin
            // rare zero keeps the two-zero rule in play
            if ($urandom_range(0, 19) == 0)
                file_buf.push_back(8'h00);
            else
                file_buf.push_back(8'($urandom_range(8'h01, 8'h7f)));
        end
        else if (k < 8)
        begin
            file_buf.push_back(8'($urandom_range(tes_pkg::LEAD2_MIN, tes_pkg::LEAD3_MIN - 1)));
            file_buf.push_back(8'($urandom_range(tes_pkg::CONT_MIN, tes_pkg::LEAD2_MIN - 1)));
        end
        else
        begin
            file_buf.push_back(8'($urandom_range(tes_pkg::LEAD3_MIN, 8'hff)));
            file_buf.push_back(8'($urandom_range(tes_pkg::CONT_MIN, tes_pkg::LEAD2_MIN - 1)));
            file_buf.push_back(8'($urandom_range(tes_pkg::CONT_MIN, tes_pkg::LEAD2_MIN - 1)));
        end
    endtask

    task automatic add_body(input body_kind_t kind, input int unsigned units);
        int unsigned i;
        int unsigned cut;
        cut = $urandom_range(0, units);
        for (i = 0; i < units; i++)
        begin
            case (kind)
                BODY_UTF16:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        file_buf.push_back(8'($urandom_range(0, 255)));
                        file_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        file_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
                        file_buf.push_back(8'h00);
                    end
                end
                BODY_NOISE:
                    file_buf.push_back(8'($urandom_range(0, 255)));
                default:
                    add_utf8_char();
            endcase
            // broken structure: stray continuation or a lead missing its tail
            if (kind == BODY_BROKEN && i == cut)
            begin
                if ($urandom_range(0, 1) == 0)
                    file_buf.push_back(8'($urandom_range(tes_pkg::CONT_MIN,
                                                         tes_pkg::LEAD2_MIN - 1)));
                else
                begin
                    file_buf.push_back(8'($urandom_range(tes_pkg::LEAD2_MIN, 8'hff)));
                    file_buf.push_back(8'($urandom_range(0, 8'h7f)));
                end
            end
        end
        // truncated final sequence
        if (kind == BODY_TRUNC)
        begin
            file_buf.push_back(8'($urandom_range(tes_pkg::LEAD2_MIN, 8'hff)));
            if (file_buf[file_buf.size() - 1] >= tes_pkg::LEAD3_MIN &&
                $urandom_range(0, 1) == 0)
                file_buf.push_back(8'($urandom_range(tes_pkg::CONT_MIN,
                                                     tes_pkg::LEAD2_MIN - 1)));
        end
    endtask

    task automatic add_mark(input mark_kind_t mark);
        case (mark)
            MARK_LE:
                file_buf = '{tes_pkg::BYTE_FF, tes_pkg::BYTE_FE};
            MARK_BE:
                file_buf = '{tes_pkg::BYTE_FE, tes_pkg::BYTE_FF};
            MARK_UTF8:
                file_buf = '{tes_pkg::BYTE_EF, tes_pkg::BYTE_BB, tes_pkg::BYTE_BF};
            MARK_PARTIAL:
            begin
                case ($urandom_range(0, 3))
                    0:       file_buf = '{tes_pkg::BYTE_FF};
                    1:       file_buf = '{tes_pkg::BYTE_FE, tes_pkg::BYTE_FE};
                    2:       file_buf = '{tes_pkg::BYTE_EF, tes_pkg::BYTE_BB};
                    default: file_buf = '{tes_pkg::BYTE_EF, tes_pkg::BYTE_BF, tes_pkg::BYTE_BB};
                endcase
            end
            default:
                file_buf.delete();
        endcase
    endtask

    task automatic send_random_file(input int unsigned max_units);
        int unsigned r;
        mark_kind_t  mark;
        body_kind_t  kind;
        r = $urandom_range(0, 99);
        if (r < 60)      mark = MARK_NONE;
        else if (r < 70) mark = MARK_LE;
        else if (r < 78) mark = MARK_BE;
        else if (r < 88) mark = MARK_UTF8;
        else             mark = MARK_PARTIAL;
        r = $urandom_range(0, 99);
        if (r < 40)      kind = BODY_UTF8;
        else if (r < 60) kind = BODY_UTF16;
        else if (r < 75) kind = BODY_NOISE;
        else if (r < 90) kind = BODY_BROKEN;
        else             kind = BODY_TRUNC;
        add_mark(mark);
        add_body(kind, $urandom_range(0, max_units));
        if (file_buf.size() == 0)
            file_buf.push_back(8'($urandom_range(0, 255)));
        send_file();
    endtask

    // result side: random stall bursts, one long hold-off on request
    initial
    begin : rx
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned tick;
        m_tready    = 1'b0;
        hold_left   = 0;
        stall_left  = 0;
        tick        = 0;
        held_cycles = 0;
        rx_idle_on  = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 48 == 0)
                rx_idle_on = ($urandom_range(0, 2) != 0);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
                held_cycles++;
            end
            else if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!calm && rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // stimulus and verdict
    initial
    begin : tx
        int unsigned rand_start;
        int unsigned drain;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        rst_n       = 1'b0;
        calm        = 1'b0;
        tx_idle_on  = 1'b1;
        hold_req    = 1'b0;
        bytes_sent  = 0;
        files_sent  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: marks, short files, zero pairs, byte extremes, broken forms
        file_buf = '{tes_pkg::BYTE_FF, tes_pkg::BYTE_FE};
        send_file();
        file_buf = '{tes_pkg::BYTE_FE, tes_pkg::BYTE_FF};
        send_file();
        file_buf = '{tes_pkg::BYTE_EF, tes_pkg::BYTE_BB, tes_pkg::BYTE_BF};
        send_file();
        file_buf = '{tes_pkg::BYTE_EF, tes_pkg::BYTE_BB};
        send_file();
        file_buf = '{tes_pkg::BYTE_FF};
        send_file();
        file_buf = '{8'h00, 8'h00};
        send_file();
        file_buf = '{8'h41};
        send_file();
        file_buf = '{tes_pkg::CONT_MIN};
        send_file();
        file_buf = '{8'hc3, 8'ha9, 8'he4, 8'hb8, 8'had};
        send_file();
        file_buf = '{8'hc3, 8'h41};
        send_file();
        file_buf = '{8'h00};
        send_file();
        file_buf = '{8'h7f, 8'hdf, tes_pkg::BYTE_BF};
        send_file();
        file_buf = '{tes_pkg::BYTE_FF, tes_pkg::BYTE_FE, 8'h41, 8'h00};
        send_file();

        // random files, mostly short
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES)
            send_random_file(20);

        // long receiver hold-off while closing bytes keep coming
        hold_req = 1'b1;
        repeat (40)
        begin
            file_buf = '{8'($urandom_range(0, 255))};
            send_file();
        end

        // tail of the run without idling on either side
        calm = 1'b1;
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < 60)
            send_random_file(8);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // drain, then watch a little longer for stray results
        repeat (3) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        drain = 20;
        repeat (drain) @(posedge clk);

        $display("Sent %0d files, %0d bytes; %0d verdicts checked.",
                 files_sent, bytes_sent, verdicts_seen);
        $display("Result side held off for %0d cycles while bytes kept arriving.", held_cycles);
        if (faults == 0 && pending == 0)
            $display("PASS text_encoding_sniffer");
        else
            $display("FAIL text_encoding_sniffer");
        $finish;
    end

endmodule
